// ----- hdl/skht_pkg.sv -----
// Package for the string key hash table: request/result types, states, constants.
// No dependencies.
`timescale 1ns / 1ps
package skht_pkg;
	localparam int SLOTS_DEF = 1024;
	localparam int KS_BYTES_DEF = 65536;
	localparam int MAX_KEY_DEF = 256;
	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;

	localparam logic [1:0] KIND_PUT = 2'd0;
	localparam logic [1:0] KIND_GET = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_FOUND = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_TABLE_FULL = 3'd4;
	localparam logic [2:0] ST_KS_FULL = 3'd5;
	localparam logic [2:0] ST_TOO_LONG = 3'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] key_byte;
		logic byte_valid;
		logic key_last;
		logic [31:0] span_start;
		logic [31:0] span_end;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] found_start;
		logic [31:0] found_end;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_RD, S_CHK, S_CMP_RD, S_CMP, S_DONE, S_COPY, S_COPY_WR, S_OUT
	} state_t;
endpackage

// ----- hdl/string_key_hash_table_top.sv -----
// Top level of the string key hash table; FNV-1a hash, linear probing, one slot a probe step.
// Depends on skht_pkg.
`timescale 1ns / 1ps
// Requests are taken when start is high and busy low. Non-final key bytes and kind 3 items
// (and non-final bytes past the length limit) stay in idle. The final byte of a put or get
// walks the probe sequencer: S_RD and S_CHK per slot visited, S_CMP_RD and S_CMP per key
// byte compared on a hash and length match; a new key adds S_COPY and S_COPY_WR per byte
// copied to the key store; S_DONE and S_OUT settle the result, which shows in the cycle
// after S_OUT. Clear and reset sweep all SLOTS (1024 by default) slot-used bits, one a cycle.
// A result shows on result with done high for one cycle and cannot be held off.
module string_key_hash_table_top #(
	parameter int SLOTS = skht_pkg::SLOTS_DEF,
	parameter int KS_BYTES = skht_pkg::KS_BYTES_DEF,
	parameter int MAX_KEY = skht_pkg::MAX_KEY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input skht_pkg::req_t req,
	output logic busy,
	output logic done,
	output skht_pkg::res_t result
);
	localparam int SW = $clog2(SLOTS);
	localparam int KW = $clog2(KS_BYTES);
	localparam int BW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int LW = $clog2(MAX_KEY + 2);
	localparam int EW = SW + 1;

	// slot memories
	logic slot_used_m [SLOTS];
	logic [31:0] slot_hash_m [SLOTS];
	logic [KW-1:0] slot_off_m [SLOTS];
	logic [LW-1:0] slot_len_m [SLOTS];
	logic [31:0] slot_st_m [SLOTS];
	logic [31:0] slot_en_m [SLOTS];
	logic [7:0] ks_m [KS_BYTES];
	logic [7:0] buf_m [MAX_KEY];

	skht_pkg::state_t state_q, state_d;
	logic [31:0] hash_q, hash_key_q;
	logic [LW-1:0] len_q, len_key_q;
	logic [KW:0] fill_q;
	logic [EW-1:0] count_q;
	logic [SW-1:0] slot_q;
	logic [SW:0] nprobe_q;
	logic [LW-1:0] idx_q;
	logic is_get_q;
	logic [31:0] st_q, en_q;
	skht_pkg::res_t res_q;
	logic done_q;

	// registered read data
	logic used_r;
	logic [31:0] hash_r, rst_r, ren_r;
	logic [KW-1:0] off_r;
	logic [LW-1:0] len_r;
	logic [7:0] ks_r, buf_r;

	logic take;
	logic [LW-1:0] len_inc;
	logic [KW:0] ks_addr_w;

	assign take = start && !busy;
	assign busy = (state_q != skht_pkg::S_IDLE);
	assign done = done_q;
	assign result = res_q;
	assign len_inc = len_q + LW'(1);
	assign ks_addr_w = fill_q + (KW+1)'(idx_q);

	always_ff @(posedge clk) begin
		used_r <= slot_used_m[slot_q];
		hash_r <= slot_hash_m[slot_q];
		off_r <= slot_off_m[slot_q];
		len_r <= slot_len_m[slot_q];
		rst_r <= slot_st_m[slot_q];
		ren_r <= slot_en_m[slot_q];
		ks_r <= ks_m[off_r + KW'(idx_q)];
		buf_r <= buf_m[idx_q[BW-1:0]];
		if (state_q == skht_pkg::S_CLR)
			slot_used_m[slot_q] <= 1'b0;
		if (take && req.kind != skht_pkg::KIND_CLEAR && req.kind != skht_pkg::KIND_UNUSED
				&& req.byte_valid && len_q < LW'(MAX_KEY))
			buf_m[len_q[BW-1:0]] <= req.key_byte;
		if (state_q == skht_pkg::S_COPY_WR)
			ks_m[ks_addr_w[KW-1:0]] <= buf_r;
		if (state_q == skht_pkg::S_DONE && res_q.status == skht_pkg::ST_UPDATED) begin
			slot_st_m[slot_q] <= st_q;
			slot_en_m[slot_q] <= en_q;
		end
		if (state_q == skht_pkg::S_DONE && res_q.status == skht_pkg::ST_INSERTED) begin
			slot_used_m[slot_q] <= 1'b1;
			slot_hash_m[slot_q] <= hash_key_q;
			slot_off_m[slot_q] <= fill_q[KW-1:0];
			slot_len_m[slot_q] <= len_key_q;
			slot_st_m[slot_q] <= st_q;
			slot_en_m[slot_q] <= en_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skht_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skht_pkg::S_IDLE: begin
				if (take) begin
					if (req.kind == skht_pkg::KIND_CLEAR)
						state_d = skht_pkg::S_CLR;
					else if (req.kind != skht_pkg::KIND_UNUSED && req.key_last)
						state_d = skht_pkg::S_RD;
				end
			end
			skht_pkg::S_CLR: begin
				if (slot_q == SW'(SLOTS - 1))
					state_d = skht_pkg::S_IDLE;
			end
			skht_pkg::S_RD: state_d = skht_pkg::S_CHK;
			skht_pkg::S_CHK: begin
				if (len_key_q > LW'(MAX_KEY))
					state_d = skht_pkg::S_DONE;
				else if (!used_r || nprobe_q == (SW+1)'(SLOTS))
					state_d = skht_pkg::S_DONE;
				else if (hash_r == hash_key_q && len_r == len_key_q)
					state_d = (len_key_q == '0) ? skht_pkg::S_DONE : skht_pkg::S_CMP_RD;
				else
					state_d = skht_pkg::S_RD;
			end
			skht_pkg::S_CMP_RD: state_d = skht_pkg::S_CMP;
			skht_pkg::S_CMP: begin
				if (ks_r != buf_r)
					state_d = skht_pkg::S_RD;
				else if (idx_q == len_key_q - LW'(1))
					state_d = skht_pkg::S_DONE;
				else
					state_d = skht_pkg::S_CMP_RD;
			end
			skht_pkg::S_DONE: begin
				if (res_q.status == skht_pkg::ST_INSERTED && len_key_q != '0)
					state_d = skht_pkg::S_COPY;
				else
					state_d = skht_pkg::S_OUT;
			end
			skht_pkg::S_COPY: state_d = skht_pkg::S_COPY_WR;
			skht_pkg::S_COPY_WR: begin
				state_d = (idx_q == len_key_q - LW'(1)) ? skht_pkg::S_OUT : skht_pkg::S_COPY;
			end
			skht_pkg::S_OUT: state_d = skht_pkg::S_IDLE;
			default: state_d = skht_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= skht_pkg::HASH_BASIS;
			len_q <= '0;
			fill_q <= '0;
			count_q <= '0;
			slot_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				skht_pkg::S_IDLE: begin
					if (take && req.kind == skht_pkg::KIND_CLEAR) begin
						hash_q <= skht_pkg::HASH_BASIS;
						len_q <= '0;
						fill_q <= '0;
						count_q <= '0;
						slot_q <= '0;
					end else if (take && req.kind != skht_pkg::KIND_UNUSED) begin
						logic [31:0] h;
						logic [LW-1:0] l;
						h = hash_q;
						l = len_q;
						if (req.byte_valid) begin
							if (len_q < LW'(MAX_KEY)) begin
								h = (hash_q ^ {24'd0, req.key_byte}) * skht_pkg::HASH_PRIME;
								l = len_inc;
							end else begin
								l = LW'(MAX_KEY + 1);
							end
						end
						if (req.key_last) begin
							hash_key_q <= h;
							len_key_q <= l;
							slot_q <= h[SW-1:0];
							hash_q <= skht_pkg::HASH_BASIS;
							len_q <= '0;
							is_get_q <= (req.kind == skht_pkg::KIND_GET);
							st_q <= req.span_start;
							en_q <= req.span_end;
							nprobe_q <= '0;
						end else begin
							hash_q <= h;
							len_q <= l;
						end
					end
				end
				skht_pkg::S_CLR: slot_q <= slot_q + SW'(1);
				skht_pkg::S_RD: idx_q <= '0;
				skht_pkg::S_CHK: begin
					if (state_d == skht_pkg::S_RD) begin
						slot_q <= slot_q + SW'(1);
						nprobe_q <= nprobe_q + (SW+1)'(1);
					end
					if (state_d == skht_pkg::S_DONE) begin
						res_q.found_start <= '0;
						res_q.found_end <= '0;
						if (len_key_q > LW'(MAX_KEY))
							res_q.status <= is_get_q ? skht_pkg::ST_NOT_FOUND
								: skht_pkg::ST_TOO_LONG;
						else if (used_r && nprobe_q != (SW+1)'(SLOTS)) begin
							res_q.status <= is_get_q ? skht_pkg::ST_FOUND : skht_pkg::ST_UPDATED;
							if (is_get_q) begin
								res_q.found_start <= rst_r;
								res_q.found_end <= ren_r;
							end
						end else if (is_get_q)
							res_q.status <= skht_pkg::ST_NOT_FOUND;
						else if ({count_q, 1'b0} + (EW+1)'(2) > (EW+1)'(SLOTS))
							res_q.status <= skht_pkg::ST_TABLE_FULL;
						else if ({1'b0, fill_q} + (KW+2)'(len_key_q) > (KW+2)'(KS_BYTES))
							res_q.status <= skht_pkg::ST_KS_FULL;
						else
							res_q.status <= skht_pkg::ST_INSERTED;
					end
				end
				skht_pkg::S_CMP_RD: ;
				skht_pkg::S_CMP: begin
					if (state_d == skht_pkg::S_RD) begin
						slot_q <= slot_q + SW'(1);
						nprobe_q <= nprobe_q + (SW+1)'(1);
					end else if (state_d == skht_pkg::S_DONE) begin
						res_q.status <= is_get_q ? skht_pkg::ST_FOUND : skht_pkg::ST_UPDATED;
						res_q.found_start <= is_get_q ? rst_r : 32'd0;
						res_q.found_end <= is_get_q ? ren_r : 32'd0;
					end else
						idx_q <= idx_q + LW'(1);
				end
				skht_pkg::S_DONE: idx_q <= '0;
				skht_pkg::S_COPY: ;
				skht_pkg::S_COPY_WR: idx_q <= idx_q + LW'(1);
				skht_pkg::S_OUT: begin
					done_q <= 1'b1;
					if (res_q.status == skht_pkg::ST_INSERTED) begin
						fill_q <= fill_q + (KW+1)'(len_key_q);
						count_q <= count_q + EW'(1);
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- tb/testbench.sv -----
// Testbench for string_key_hash_table_top: directed, fill-to-limit and random key traffic.
// Self-checking against an in-bench table predictor; depends on skht_pkg and the top level.
`timescale 1ns / 1ps
module testbench;
	localparam int NSLOT = skht_pkg::SLOTS_DEF;
	localparam int NSTORE = skht_pkg::KS_BYTES_DEF;
	localparam int NKEY = skht_pkg::MAX_KEY_DEF;
	localparam int STALL_LIMIT = 2000000;

	class span_table_board;
		bit used[NSLOT];
		logic [31:0] hash_of[NSLOT];
		int key_off[NSLOT];
		int key_len[NSLOT];
		logic [31:0] start_of[NSLOT];
		logic [31:0] end_of[NSLOT];
		logic [7:0] store[NSTORE];
		logic [7:0] pending_key[NKEY];
		int store_fill;
		logic [31:0] acc_hash;
		int acc_len;
		int entries;
		skht_pkg::res_t awaited[$];
		int errors;

		function void wipe();
			for (int i = 0; i < NSLOT; i++) used[i] = 0;
			entries = 0;
			store_fill = 0;
			acc_hash = skht_pkg::HASH_BASIS;
			acc_len = 0;
		endfunction

		function bit same_key(int s, logic [31:0] h, int len);
			if (hash_of[s] != h || key_len[s] != len) return 0;
			for (int i = 0; i < len; i++)
				if (store[key_off[s] + i] != pending_key[i]) return 0;
			return 1;
		endfunction

		// returns matching slot or first free one
		function int find_slot(logic [31:0] h, int len, output bit hit);
			int s;
			s = h & (NSLOT - 1);
			hit = 0;
			for (int n = 0; n < NSLOT; n++) begin
				if (!used[s]) return s;
				if (same_key(s, h, len)) begin
					hit = 1;
					return s;
				end
				s = (s + 1) & (NSLOT - 1);
			end
			return s;
		endfunction

		function void note_request(skht_pkg::req_t r);
			logic [31:0] h;
			int len, s;
			bit hit;
			skht_pkg::res_t o;
			if (r.kind == skht_pkg::KIND_CLEAR) begin
				wipe();
				return;
			end
			if (r.kind == skht_pkg::KIND_UNUSED) return;
			if (r.byte_valid) begin
				if (acc_len < NKEY) begin
					pending_key[acc_len] = r.key_byte;
					acc_hash = (acc_hash ^ {24'd0, r.key_byte}) * skht_pkg::HASH_PRIME;
					acc_len++;
				end else
					acc_len = NKEY + 1;
			end
			if (!r.key_last) return;
			h = acc_hash;
			len = acc_len;
			acc_hash = skht_pkg::HASH_BASIS;
			acc_len = 0;
			o = '0;
			if (r.kind == skht_pkg::KIND_GET) begin
				o.status = skht_pkg::ST_NOT_FOUND;
				if (len <= NKEY) begin
					s = find_slot(h, len, hit);
					if (hit) begin
						o.status = skht_pkg::ST_FOUND;
						o.found_start = start_of[s];
						o.found_end = end_of[s];
					end
				end
			end else if (len > NKEY)
				o.status = skht_pkg::ST_TOO_LONG;
			else begin
				s = find_slot(h, len, hit);
				if (hit) begin
					start_of[s] = r.span_start;
					end_of[s] = r.span_end;
					o.status = skht_pkg::ST_UPDATED;
				end else if ((entries + 1) * 2 > NSLOT)
					o.status = skht_pkg::ST_TABLE_FULL;
				else if (store_fill + len > NSTORE)
					o.status = skht_pkg::ST_KS_FULL;
				else begin
					for (int i = 0; i < len; i++) store[store_fill + i] = pending_key[i];
					used[s] = 1;
					hash_of[s] = h;
					key_off[s] = store_fill;
					key_len[s] = len;
					start_of[s] = r.span_start;
					end_of[s] = r.span_end;
					store_fill += len;
					entries++;
					o.status = skht_pkg::ST_INSERTED;
				end
			end
			awaited.push_back(o);
		endfunction

		function void check_result(skht_pkg::res_t got);
			skht_pkg::res_t e;
			if (awaited.size() == 0) begin
				$display("%t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.status !== e.status) begin
				$display("%t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.found_start !== e.found_start) begin
				$display("%t: found_start expected %h actual %h", $time, e.found_start,
					got.found_start);
				errors++;
			end
			if (got.found_end !== e.found_end) begin
				$display("%t: found_end expected %h actual %h", $time, e.found_end,
					got.found_end);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	skht_pkg::req_t req = '0;
	logic busy, done;
	skht_pkg::res_t result;
	span_table_board board = new();
	int quiet_cycles = 0;
	bit allow_gaps = 1;

	string_key_hash_table_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_result(result);
			if (start && !busy) board.note_request(req);
			if (done || (start && !busy)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// one request, with an optional idle burst ahead of it
	task automatic send(skht_pkg::req_t r);
		if (allow_gaps && $urandom_range(0, 5) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1;
		req <= r;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic send_item(logic [1:0] kind, logic [7:0] b, logic v, logic l);
		skht_pkg::req_t r;
		r.kind = kind;
		r.key_byte = b;
		r.byte_valid = v;
		r.key_last = l;
		r.span_start = $urandom;
		r.span_end = $urandom;
		send(r);
	endtask

	task automatic send_key(logic [7:0] key[$], logic [1:0] kind, logic [31:0] st,
			logic [31:0] en);
		skht_pkg::req_t r;
		r.kind = kind;
		r.span_start = st;
		r.span_end = en;
		if (key.size() == 0) begin
			r.key_byte = 8'($urandom);
			r.byte_valid = 0;
			r.key_last = 1;
			send(r);
		end
		for (int i = 0; i < key.size(); i++) begin
			r.key_byte = key[i];
			r.byte_valid = 1;
			r.key_last = (i == key.size() - 1);
			send(r);
		end
	endtask

	task automatic drain();
		start <= 0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (2500) @(posedge clk);
	endtask

	initial begin
		logic [7:0] k[$];
		logic [7:0] pool[16][$];
		logic [1:0] kd;
		int n;
		board.errors = 0;
		board.wipe();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty key, extremes of bytes and spans, update, miss
		k = {};
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		send_key(k, skht_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h0);
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		k = {8'h00};
		send_key(k, skht_pkg::KIND_PUT, 32'h0, 32'hFFFF_FFFF);
		k = {8'hFF, 8'hA5};
		send_key(k, skht_pkg::KIND_PUT, 32'h1234_5678, 32'h9ABC_DEF0);
		send_key(k, skht_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		k = {8'h00};
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		k = {8'h5A};
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		// unused kind and a byte-less item in the middle of a key, mixed kinds
		send_item(skht_pkg::KIND_PUT, 8'hFF, 1'b1, 1'b0);
		send_item(skht_pkg::KIND_UNUSED, 8'h11, 1'b1, 1'b1);
		send_item(skht_pkg::KIND_GET, 8'h22, 1'b0, 1'b0);
		send_item(skht_pkg::KIND_GET, 8'hA5, 1'b1, 1'b0);
		send_item(skht_pkg::KIND_GET, 8'h00, 1'b0, 1'b1);
		// clear drops a partial key
		send_item(skht_pkg::KIND_PUT, 8'h77, 1'b1, 1'b0);
		send_item(skht_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b0);
		k = {8'hFF, 8'hA5};
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		// key one byte past the limit
		k = {};
		for (int i = 0; i < NKEY + 1; i++) k.push_back(8'($urandom));
		send_key(k, skht_pkg::KIND_PUT, 1, 2);
		drain();

		// table full at half load: empty key, one-byte keys, then two-byte keys
		send_item(skht_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b0);
		k = {};
		send_key(k, skht_pkg::KIND_PUT, $urandom, $urandom);
		for (int i = 0; i < 256; i++) begin
			k = {8'(i)};
			send_key(k, skht_pkg::KIND_PUT, $urandom, $urandom);
		end
		for (int i = 0; i < NSLOT / 2 - 256; i++) begin
			k = {8'h00, 8'(i)};
			send_key(k, skht_pkg::KIND_PUT, $urandom, $urandom);
		end
		// the last put above was refused
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		k = {8'h00, 8'h05};
		send_key(k, skht_pkg::KIND_PUT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		send_key(k, skht_pkg::KIND_GET, 0, 0);
		drain();
		send_item(skht_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b0);

		// random traffic over a small key pool so hits are common
		for (int p = 0; p < 16; p++) begin
			pool[p] = {};
			repeat ($urandom_range(0, 5)) pool[p].push_back(8'($urandom));
		end
		n = 0;
		while (n < 200) begin
			if (n > 160) allow_gaps = 0;
			case ($urandom_range(0, 99))
				0: begin
					send_item(skht_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
					n++;
				end
				1, 2, 3: begin
					send_item(skht_pkg::KIND_UNUSED, 8'($urandom), 1'($urandom),
						1'($urandom));
					n++;
				end
				4, 5, 6: begin
					send_item(2'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0);
					n++;
				end
				default: begin
					if ($urandom_range(0, 4) == 0) begin
						k = {};
						repeat ($urandom_range(0, 6)) k.push_back(8'($urandom));
					end else
						k = pool[$urandom_range(0, 15)];
					kd = 2'($urandom_range(0, 1));
					for (int i = 0; i + 1 < k.size(); i++)
						send_item($urandom_range(0, 3) == 0 ? ~kd & 2'd1 : kd, k[i], 1'b1,
							1'b0);
					if (k.size() == 0 || $urandom_range(0, 7) == 0) begin
						if (k.size() != 0) send_item(kd, k[k.size() - 1], 1'b1, 1'b0);
						send_item(kd, 8'($urandom), 1'b0, 1'b1);
					end else
						send_item(kd, k[k.size() - 1], 1'b1, 1'b1);
					n += k.size() + 1;
				end
			endcase
		end
		drain();

		if (board.errors == 0 && board.awaited.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
